/* rtl/http_request_header_parser_core_defines.svh */
// Assertion macros for the HTTP request header parser.
// Included by the top level; expects clk and rst_n in scope.
`ifndef HTTP_REQUEST_HEADER_PARSER_CORE_DEFINES_SVH
`define HTTP_REQUEST_HEADER_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define HRP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define HRP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/hrp_pkg.sv */
// Shared types, constants and character tables for the HTTP request parser.
// No dependencies; used by every RTL file.
package hrp_pkg;

  localparam int POS_W = 17;
  localparam logic [POS_W-1:0] BUF_LIMIT = 17'h10000;
  localparam logic [POS_W-1:0] NUM_SAT   = 17'h10001;
  localparam int ACC_W = POS_W + 4;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_QM    = 8'h3F;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_X_UP  = 8'h58;
  localparam logic [7:0] CH_X_LO  = 8'h78;

  localparam logic [8*6-1:0]  TXT_HOST   = "Host: ";
  localparam logic [8*13-1:0] TXT_COOKIE = "Cookie: name=";
  localparam logic [8*16-1:0] TXT_CLEN   = "Content-Length: ";
  localparam logic [8*4-1:0]  TXT_GET    = "GET ";
  localparam logic [8*5-1:0]  TXT_POST   = "POST ";

  localparam logic [1:0] PFX_HOST   = 2'd0;
  localparam logic [1:0] PFX_COOKIE = 2'd1;
  localparam logic [1:0] PFX_CLEN   = 2'd2;

  typedef enum logic [3:0] {
    PH_METHOD, PH_SLASH, PH_PATH, PH_PREFIX, PH_LINE_CR, PH_VALUE, PH_NUM_WS,
    PH_NUM_SIGN, PH_NUM_ZERO, PH_NUM_X, PH_NUM_DIGITS, PH_BODY, PH_ERROR
  } phase_t;

  typedef enum logic [1:0] {KIND_NONE, KIND_HOST, KIND_COOKIE} kind_t;

  typedef enum logic [1:0] {RADIX_OCT, RADIX_DEC, RADIX_HEX} radix_t;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       ends;
    logic       is_nul;
    logic       is_ws;
    logic       hex_ok;
    logic [3:0] dig;
  } byte_info_t;

  typedef struct packed {
    logic             status;
    logic             is_post;
    logic [POS_W-1:0] path_length;
    logic [POS_W-1:0] query_offset;
    logic [POS_W-1:0] query_length;
    logic [POS_W-1:0] host_offset;
    logic [POS_W-1:0] host_length;
    logic [POS_W-1:0] cookie_offset;
    logic [POS_W-1:0] cookie_length;
    logic [POS_W-1:0] body_length;
    logic [POS_W-1:0] body_offset;
  } result_t;

  function automatic logic [4:0] prefix_len(input logic [1:0] k);
    logic [4:0] n;
    n = 5'd0;
    unique case (k)
      PFX_HOST:   n = 5'd6;
      PFX_COOKIE: n = 5'd13;
      PFX_CLEN:   n = 5'd16;
      default:    n = 5'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] prefix_char(input logic [1:0] k, input logic [4:0] i);
    logic [7:0] c;
    c = 8'h00;
    unique case (k)
      PFX_HOST:   if (i < 5'd6)  c = TXT_HOST[8*(5 - int'(i)) +: 8];
      PFX_COOKIE: if (i < 5'd13) c = TXT_COOKIE[8*(12 - int'(i)) +: 8];
      PFX_CLEN:   if (i < 5'd16) c = TXT_CLEN[8*(15 - int'(i)) +: 8];
      default:    c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] method_char(input logic post, input logic [4:0] i);
    logic [7:0] c;
    c = 8'h00;
    if (post) begin
      if (i < 5'd5) c = TXT_POST[8*(4 - int'(i)) +: 8];
    end else begin
      if (i < 5'd4) c = TXT_GET[8*(3 - int'(i)) +: 8];
    end
    return c;
  endfunction

endpackage

/* rtl/hrp_ifs.sv */
// Valid/ready channel interfaces for request bytes and parse results.
// Depends on hrp_pkg for field widths.
interface hrp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       starts_request;
  logic       ends_read;
  modport source (output valid, data_byte, starts_request, ends_read, input ready);
  modport sink (input valid, data_byte, starts_request, ends_read, output ready);
endinterface

interface hrp_out_if;
  logic                     valid;
  logic                     ready;
  logic                     status;
  logic                     is_post;
  logic [hrp_pkg::POS_W-1:0] path_length;
  logic [hrp_pkg::POS_W-1:0] query_offset;
  logic [hrp_pkg::POS_W-1:0] query_length;
  logic [hrp_pkg::POS_W-1:0] host_offset;
  logic [hrp_pkg::POS_W-1:0] host_length;
  logic [hrp_pkg::POS_W-1:0] cookie_offset;
  logic [hrp_pkg::POS_W-1:0] cookie_length;
  logic [hrp_pkg::POS_W-1:0] body_length;
  logic [hrp_pkg::POS_W-1:0] body_offset;
  modport source (output valid, status, is_post, path_length, query_offset, query_length,
                  host_offset, host_length, cookie_offset, cookie_length, body_length,
                  body_offset, input ready);
  modport sink (input valid, status, is_post, path_length, query_offset, query_length,
                host_offset, host_length, cookie_offset, cookie_length, body_length,
                body_offset, output ready);
endinterface

/* rtl/http_request_header_parser_core.sv */
// Top level of the HTTP request header parser: front end, byte queue, parser.
// Depends on hrp_pkg, hrp_ifs, hrp_front, hrp_queue, hrp_back and the defines header.
//
//   channel   direction  payload
//   in_if     sink       data_byte, starts_request, ends_read
//   out_if    source     status, is_post, path/query/host/cookie/body fields
//
// One byte per cycle while the result is not stalled; the parser consumes a byte per
// cycle from a four-entry queue and a result is registered at the edge after the parser
// takes its last byte, which is first written into the queue on its transfer.
// Reset (rst_n low, synchronous) empties the queue and clears the parser.
// A stalled result holds the parser; the queue keeps taking bytes until full.
`include "http_request_header_parser_core_defines.svh"

module http_request_header_parser_core (
  input  logic       clk,
  input  logic       rst_n,
  hrp_in_if.sink     in_if,
  hrp_out_if.source  out_if
);

  logic                push, q_full, q_pop, q_valid, res_valid;
  hrp_pkg::byte_info_t push_item, q_head;
  hrp_pkg::result_t    res;

  hrp_front u_front (
    .in_if     (in_if),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  hrp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  hrp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_head),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (out_if.ready)
  );

  assign out_if.valid         = res_valid;
  assign out_if.status        = res.status;
  assign out_if.is_post       = res.is_post;
  assign out_if.path_length   = res.path_length;
  assign out_if.query_offset  = res.query_offset;
  assign out_if.query_length  = res.query_length;
  assign out_if.host_offset   = res.host_offset;
  assign out_if.host_length   = res.host_length;
  assign out_if.cookie_offset = res.cookie_offset;
  assign out_if.cookie_length = res.cookie_length;
  assign out_if.body_length   = res.body_length;
  assign out_if.body_offset   = res.body_offset;

  `HRP_ASSERT_SAME(a_pop_needs_item, q_pop, q_valid, "parser popped an empty queue")
  `HRP_ASSERT_SAME(a_stall_only_full, !in_if.ready, q_full, "input stalled with queue space")
  `HRP_ASSERT_NEXT(a_result_from_pop, !res_valid && !q_pop, !res_valid, "result without byte")

endmodule

/* rtl/hrp_front.sv */
// Front end: accepts request bytes and tags each with its character class.
// Depends on hrp_pkg and hrp_in_if.
module hrp_front (
  hrp_in_if.sink               in_if,
  input  logic                 q_full,
  output logic                 push,
  output hrp_pkg::byte_info_t  push_item
);

  logic [7:0] b;

  assign b = in_if.data_byte;
  assign in_if.ready = !q_full;
  assign push = in_if.valid && !q_full;

  always_comb begin
    push_item        = '0;
    push_item.data   = b;
    push_item.start  = in_if.starts_request;
    push_item.ends   = in_if.ends_read;
    push_item.is_nul = (b == hrp_pkg::CH_NUL);
    push_item.is_ws  = (b == hrp_pkg::CH_SP) || (b == hrp_pkg::CH_TAB) ||
                       (b == hrp_pkg::CH_VT) || (b == hrp_pkg::CH_FF);
    if (b >= 8'h30 && b <= 8'h39) begin
      push_item.hex_ok = 1'b1;
      push_item.dig    = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      push_item.hex_ok = 1'b1;
      push_item.dig    = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      push_item.hex_ok = 1'b1;
      push_item.dig    = 4'(b - 8'h37);
    end
  end

endmodule

/* rtl/hrp_queue.sv */
// Short FIFO of classified bytes between the front end and the parser.
// Depends on hrp_pkg.
module hrp_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  hrp_pkg::byte_info_t push_item,
  output logic                full,
  input  logic                pop,
  output logic                valid,
  output hrp_pkg::byte_info_t head
);

  hrp_pkg::byte_info_t entry_r [hrp_pkg::QDEPTH];
  logic [hrp_pkg::QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [hrp_pkg::QPTR_W:0]   count_r;

  assign full  = (count_r == (hrp_pkg::QPTR_W+1)'(hrp_pkg::QDEPTH));
  assign valid = (count_r != '0);
  assign head  = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop) count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_item;
  end

endmodule

/* rtl/hrp_back.sv */
// Parser: walks the request one byte per cycle while the result is not stalled and registers the result.
// Depends on hrp_pkg.
module hrp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  hrp_pkg::byte_info_t q_item,
  output logic                q_pop,
  output logic                res_valid,
  output hrp_pkg::result_t    res,
  input  logic                res_ready
);

  localparam int W = hrp_pkg::POS_W;

  hrp_pkg::phase_t ph_r, ph_nxt, c_ph;
  hrp_pkg::kind_t  kind_r, kind_nxt, c_kind;
  hrp_pkg::radix_t radix_r, radix_nxt, c_radix;
  logic [W-1:0] pos_r, pos_nxt, c_pos;
  logic [4:0]   match_r, match_nxt, c_match;
  logic [2:0]   cand_r, cand_nxt, c_cand;
  logic [W-1:0] num_r, num_nxt, c_num;
  logic [W-1:0] pstart_r, pstart_nxt, c_pstart;
  logic [W-1:0] plen_r, plen_nxt, c_plen;
  logic [W-1:0] qoff_r, qoff_nxt, c_qoff;
  logic [W-1:0] qlen_r, qlen_nxt, c_qlen;
  logic [W-1:0] hoff_r, hoff_nxt, c_hoff;
  logic [W-1:0] hlen_r, hlen_nxt, c_hlen;
  logic [W-1:0] coff_r, coff_nxt, c_coff;
  logic [W-1:0] clen_r, clen_nxt, c_clen;
  logic [W-1:0] blen_r, blen_nxt, c_blen;
  logic [W-1:0] boff_r, boff_nxt, c_boff;
  logic post_r, post_nxt, c_post;
  logic done_r, done_nxt, c_done;
  logic cr_r, cr_nxt, c_cr;
  logic neg_r, neg_nxt, c_neg;

  logic             res_valid_r, res_valid_nxt;
  hrp_pkg::result_t res_r, res_nxt;

  logic       clr;
  logic [7:0] b;
  logic       emit, bad, post_v, sign_step, dig_ok, finish;
  logic [4:0] wlen, mi;
  logic [2:0] nc;
  logic [hrp_pkg::ACC_W-1:0] acc;
  logic [W-1:0] body_seen;

  assign q_pop     = q_valid && (!res_valid_r || res_ready);
  assign clr       = q_pop && q_item.start;
  assign b         = q_item.data;
  assign res_valid = res_valid_r;
  assign res       = res_r;

  // Current state: a request start clears the parser before its byte is taken.
  always_comb begin
    c_ph = clr ? hrp_pkg::PH_METHOD : ph_r;
    c_kind = clr ? hrp_pkg::KIND_NONE : kind_r;
    c_radix = clr ? hrp_pkg::RADIX_DEC : radix_r;
    c_pos = clr ? '0 : pos_r;
    c_match = clr ? '0 : match_r;
    c_cand = clr ? 3'b111 : cand_r;
    c_num = clr ? '0 : num_r;
    c_pstart = clr ? '0 : pstart_r;
    c_plen = clr ? '0 : plen_r;
    c_qoff = clr ? '0 : qoff_r;
    c_qlen = clr ? '0 : qlen_r;
    c_hoff = clr ? '0 : hoff_r;
    c_hlen = clr ? '0 : hlen_r;
    c_coff = clr ? '0 : coff_r;
    c_clen = clr ? '0 : clen_r;
    c_blen = clr ? '0 : blen_r;
    c_boff = clr ? '0 : boff_r;
    c_post = clr ? 1'b0 : post_r;
    c_done = clr ? 1'b0 : done_r;
    c_cr = clr ? 1'b0 : cr_r;
    c_neg = clr ? 1'b0 : neg_r;
  end

  always_comb begin
    unique case (c_radix)
      hrp_pkg::RADIX_OCT: acc = hrp_pkg::ACC_W'({c_num, 3'b000}) +
                                hrp_pkg::ACC_W'(q_item.dig);
      hrp_pkg::RADIX_HEX: acc = hrp_pkg::ACC_W'({c_num, 4'b0000}) +
                                hrp_pkg::ACC_W'(q_item.dig);
      default: acc = hrp_pkg::ACC_W'({c_num, 3'b000}) + hrp_pkg::ACC_W'({c_num, 1'b0}) +
                     hrp_pkg::ACC_W'(q_item.dig);
    endcase
    unique case (c_radix)
      hrp_pkg::RADIX_OCT: dig_ok = q_item.hex_ok && (q_item.dig < 4'd8);
      hrp_pkg::RADIX_HEX: dig_ok = q_item.hex_ok;
      default:            dig_ok = q_item.hex_ok && (q_item.dig < 4'd10);
    endcase
  end

  always_comb begin
    ph_nxt = c_ph; kind_nxt = c_kind; radix_nxt = c_radix; pos_nxt = c_pos;
    match_nxt = c_match; cand_nxt = c_cand; num_nxt = c_num; pstart_nxt = c_pstart;
    plen_nxt = c_plen; qoff_nxt = c_qoff; qlen_nxt = c_qlen; hoff_nxt = c_hoff;
    hlen_nxt = c_hlen; coff_nxt = c_coff; clen_nxt = c_clen; blen_nxt = c_blen;
    boff_nxt = c_boff; post_nxt = c_post; done_nxt = c_done; cr_nxt = c_cr;
    neg_nxt = c_neg;
    emit = 1'b0; bad = 1'b0; post_v = c_post; sign_step = 1'b0; finish = 1'b0;
    wlen = 5'd4; mi = c_match; nc = '0; body_seen = '0;

    if (q_pop && !c_done) begin
      if (c_pos >= hrp_pkg::BUF_LIMIT) begin
        emit = 1'b1;
        bad  = 1'b1;
      end else begin
        pos_nxt = c_pos + 1'b1;
        if (c_ph != hrp_pkg::PH_BODY && c_ph != hrp_pkg::PH_ERROR && q_item.is_nul) begin
          ph_nxt = hrp_pkg::PH_ERROR;
        end else begin
          unique case (c_ph)
            hrp_pkg::PH_METHOD: begin
              if (c_match == 5'd0) begin
                if (b == hrp_pkg::CH_G) post_v = 1'b0;
                else if (b == hrp_pkg::CH_P) post_v = 1'b1;
              end
              post_nxt = post_v;
              wlen = post_v ? 5'd5 : 5'd4;
              if ((c_match == 5'd0 && b != hrp_pkg::CH_G && b != hrp_pkg::CH_P) ||
                  c_match >= wlen || hrp_pkg::method_char(post_v, c_match) != b) begin
                ph_nxt = hrp_pkg::PH_ERROR;
              end else begin
                match_nxt = c_match + 1'b1;
                if (c_match + 5'd1 == wlen) ph_nxt = hrp_pkg::PH_SLASH;
              end
            end
            hrp_pkg::PH_SLASH: begin
              if (b == hrp_pkg::CH_SLASH) begin
                pstart_nxt = c_pos + 1'b1;
                ph_nxt = hrp_pkg::PH_PATH;
              end else begin
                ph_nxt = hrp_pkg::PH_ERROR;
              end
            end
            hrp_pkg::PH_PATH: begin
              if (b == hrp_pkg::CH_QM) begin
                if (c_qoff == '0) plen_nxt = c_pos - c_pstart;
                qoff_nxt = c_pos + 1'b1;
              end else if (b == hrp_pkg::CH_SP) begin
                if (c_qoff == '0) plen_nxt = c_pos - c_pstart;
                else qlen_nxt = c_pos - c_qoff;
                ph_nxt = hrp_pkg::PH_VALUE;
                kind_nxt = hrp_pkg::KIND_NONE;
                cr_nxt = 1'b0;
              end
            end
            hrp_pkg::PH_PREFIX: begin
              for (int k = 0; k < 3; k++) begin
                if (c_cand[k] && c_match < hrp_pkg::prefix_len(2'(k)) &&
                    hrp_pkg::prefix_char(2'(k), c_match) == b) nc[k] = 1'b1;
              end
              if (nc == '0) begin
                if (c_match == 5'd0 && b == hrp_pkg::CH_CR) begin
                  ph_nxt = hrp_pkg::PH_LINE_CR;
                end else begin
                  ph_nxt = hrp_pkg::PH_VALUE;
                  kind_nxt = hrp_pkg::KIND_NONE;
                  cr_nxt = (c_match != 5'd0) && (b == hrp_pkg::CH_CR);
                end
              end else begin
                mi = c_match + 1'b1;
                cand_nxt = nc;
                match_nxt = mi;
                priority if (nc[0] && mi == hrp_pkg::prefix_len(hrp_pkg::PFX_HOST)) begin
                  hoff_nxt = c_pos + 1'b1;
                  ph_nxt = hrp_pkg::PH_VALUE;
                  kind_nxt = hrp_pkg::KIND_HOST;
                  cr_nxt = 1'b0;
                end else if (nc[1] && mi == hrp_pkg::prefix_len(hrp_pkg::PFX_COOKIE)) begin
                  coff_nxt = c_pos + 1'b1;
                  ph_nxt = hrp_pkg::PH_VALUE;
                  kind_nxt = hrp_pkg::KIND_COOKIE;
                  cr_nxt = 1'b0;
                end else if (nc[2] && mi == hrp_pkg::prefix_len(hrp_pkg::PFX_CLEN)) begin
                  num_nxt = '0;
                  radix_nxt = hrp_pkg::RADIX_DEC;
                  neg_nxt = 1'b0;
                  ph_nxt = hrp_pkg::PH_NUM_WS;
                end else begin
                  ph_nxt = c_ph;
                end
              end
            end
            hrp_pkg::PH_LINE_CR: begin
              if (b == hrp_pkg::CH_LF) begin
                boff_nxt = c_pos + 1'b1;
                if (c_blen != '0 && (!c_post || c_blen > hrp_pkg::BUF_LIMIT))
                  ph_nxt = hrp_pkg::PH_ERROR;
                else
                  ph_nxt = hrp_pkg::PH_BODY;
              end else begin
                ph_nxt = hrp_pkg::PH_VALUE;
                kind_nxt = hrp_pkg::KIND_NONE;
                cr_nxt = (b == hrp_pkg::CH_CR);
              end
            end
            hrp_pkg::PH_VALUE: begin
              if (c_cr && b == hrp_pkg::CH_LF) begin
                if (c_kind == hrp_pkg::KIND_HOST) hlen_nxt = (c_pos - 1'b1) - c_hoff;
                else if (c_kind == hrp_pkg::KIND_COOKIE) clen_nxt = (c_pos - 1'b1) - c_coff;
                ph_nxt = hrp_pkg::PH_PREFIX;
                match_nxt = '0;
                cand_nxt = 3'b111;
                kind_nxt = hrp_pkg::KIND_NONE;
                cr_nxt = 1'b0;
              end else begin
                cr_nxt = (b == hrp_pkg::CH_CR);
              end
            end
            hrp_pkg::PH_NUM_WS: begin
              if (q_item.is_ws) begin
                ph_nxt = c_ph;
              end else if (b == hrp_pkg::CH_PLUS || b == hrp_pkg::CH_MINUS) begin
                neg_nxt = (b == hrp_pkg::CH_MINUS);
                ph_nxt = hrp_pkg::PH_NUM_SIGN;
              end else begin
                sign_step = 1'b1;
              end
            end
            hrp_pkg::PH_NUM_SIGN: sign_step = 1'b1;
            hrp_pkg::PH_NUM_ZERO: begin
              if (b == hrp_pkg::CH_X_LO || b == hrp_pkg::CH_X_UP) begin
                ph_nxt = hrp_pkg::PH_NUM_X;
              end else if (b >= hrp_pkg::CH_ZERO && b <= hrp_pkg::CH_SEVEN) begin
                num_nxt = W'(q_item.dig);
                radix_nxt = hrp_pkg::RADIX_OCT;
                ph_nxt = hrp_pkg::PH_NUM_DIGITS;
              end else begin
                finish = 1'b1;
              end
            end
            hrp_pkg::PH_NUM_X: begin
              if (q_item.hex_ok) begin
                num_nxt = W'(q_item.dig);
                radix_nxt = hrp_pkg::RADIX_HEX;
                ph_nxt = hrp_pkg::PH_NUM_DIGITS;
              end else begin
                finish = 1'b1;
              end
            end
            hrp_pkg::PH_NUM_DIGITS: begin
              if (dig_ok) begin
                // saturate just above the buffer limit
                if (acc > hrp_pkg::ACC_W'(hrp_pkg::NUM_SAT)) num_nxt = hrp_pkg::NUM_SAT;
                else num_nxt = acc[W-1:0];
              end else begin
                finish = 1'b1;
              end
            end
            hrp_pkg::PH_BODY, hrp_pkg::PH_ERROR: ph_nxt = c_ph;
            default: ph_nxt = c_ph;
          endcase

          if (sign_step) begin
            if (b == hrp_pkg::CH_ZERO) begin
              ph_nxt = hrp_pkg::PH_NUM_ZERO;
            end else if (b >= hrp_pkg::CH_ONE && b <= hrp_pkg::CH_NINE) begin
              num_nxt = W'(q_item.dig);
              radix_nxt = hrp_pkg::RADIX_DEC;
              ph_nxt = hrp_pkg::PH_NUM_DIGITS;
            end else begin
              finish = 1'b1;
            end
          end

          if (finish) begin
            blen_nxt = c_neg ? '0 : c_num;
            ph_nxt = hrp_pkg::PH_VALUE;
            kind_nxt = hrp_pkg::KIND_NONE;
            cr_nxt = (b == hrp_pkg::CH_CR);
          end
        end

        if (q_item.ends) begin
          body_seen = pos_nxt - boff_nxt;
          if (ph_nxt == hrp_pkg::PH_BODY) begin
            emit = (body_seen >= blen_nxt);
          end else begin
            emit = 1'b1;
            bad  = 1'b1;
          end
        end
      end
      if (emit) done_nxt = 1'b1;
    end
  end

  always_comb begin
    res_valid_nxt = res_valid_r;
    res_nxt = res_r;
    if (q_pop) res_valid_nxt = emit;
    else if (res_ready) res_valid_nxt = 1'b0;
    if (emit) begin
      if (bad) begin
        res_nxt = '0;
        res_nxt.status = 1'b1;
      end else begin
        res_nxt.status        = 1'b0;
        res_nxt.is_post       = post_nxt;
        res_nxt.path_length   = plen_nxt;
        res_nxt.query_offset  = qoff_nxt;
        res_nxt.query_length  = qlen_nxt;
        res_nxt.host_offset   = hoff_nxt;
        res_nxt.host_length   = hlen_nxt;
        res_nxt.cookie_offset = coff_nxt;
        res_nxt.cookie_length = clen_nxt;
        res_nxt.body_length   = blen_nxt;
        res_nxt.body_offset   = boff_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= hrp_pkg::PH_METHOD;
      kind_r <= hrp_pkg::KIND_NONE;
      radix_r <= hrp_pkg::RADIX_DEC;
      pos_r <= '0; match_r <= '0; cand_r <= 3'b111; num_r <= '0;
      pstart_r <= '0; plen_r <= '0; qoff_r <= '0; qlen_r <= '0;
      hoff_r <= '0; hlen_r <= '0; coff_r <= '0; clen_r <= '0;
      blen_r <= '0; boff_r <= '0;
      post_r <= 1'b0; done_r <= 1'b0; cr_r <= 1'b0; neg_r <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      ph_r <= ph_nxt; kind_r <= kind_nxt; radix_r <= radix_nxt;
      pos_r <= pos_nxt; match_r <= match_nxt; cand_r <= cand_nxt; num_r <= num_nxt;
      pstart_r <= pstart_nxt; plen_r <= plen_nxt; qoff_r <= qoff_nxt; qlen_r <= qlen_nxt;
      hoff_r <= hoff_nxt; hlen_r <= hlen_nxt; coff_r <= coff_nxt; clen_r <= clen_nxt;
      blen_r <= blen_nxt; boff_r <= boff_nxt;
      post_r <= post_nxt; done_r <= done_nxt; cr_r <= cr_nxt; neg_r <= neg_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

endmodule
